@@ design/cbr_pkg.sv @@
// Package for the battery charge regulator: shared types, timing constants,
// register indexes, fan codes and the duty step function.
// Depends on nothing; every other design file imports it.
package cbr_pkg;

    // PWM period in counts and the resulting duty range.
    localparam int PWM_PERIOD = 1024;
    localparam int DUTY_W     = 10;
    typedef logic [DUTY_W-1:0] duty_t;
    localparam duty_t DUTY_MAX = duty_t'(PWM_PERIOD - PWM_PERIOD / 8);

    // Time constants in milliseconds.
    localparam logic [31:0] STARTUP_MS     = 32'd30000;
    localparam logic [31:0] PROBE_START_MS = 32'd60000;
    localparam logic [31:0] PROBE_END_MS   = 32'd60500;
    localparam logic [31:0] HOLD_OFF_MS    = 32'd120000;
    localparam logic [31:0] STALE_MS       = 32'd180000;

    // Solar margin and the taper thresholds (per mille of full voltage).
    localparam logic [16:0] SOLAR_MARGIN_MV = 17'd2000;
    localparam logic [25:0] TAPER_SCALE     = 26'd1000;
    localparam logic [25:0] TAPER_FINE      = 26'd13;
    localparam logic [25:0] TAPER_MID       = 26'd27;
    localparam logic [25:0] TAPER_COARSE    = 26'd41;

    // Fan command codes.
    localparam logic [1:0] FAN_LEAVE = 2'd0;
    localparam logic [1:0] FAN_HALF  = 2'd1;
    localparam logic [1:0] FAN_OFF   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE_MAIN     = 3'd0,
        REG_ENABLE_SOLAR    = 3'd1,
        REG_MIN_DIFF_MV     = 3'd2,
        REG_MAX_BATT_MV     = 3'd3,
        REG_CHARGE_START_MV = 3'd4,
        REG_MIN_SOLAR_MV    = 3'd5,
        REG_MAX_CHARGE_MA   = 3'd6,
        REG_POWER_SAVE      = 3'd7
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic        enable_main;
        logic        enable_solar;
        logic [15:0] min_diff_mv;
        logic [15:0] max_batt_mv;
        logic [15:0] charge_start_mv;
        logic [15:0] min_solar_mv;
        logic [14:0] max_charge_ma;
        logic        power_save;
    } cfg_t;

    // One poll as it enters the regulator.
    typedef struct packed {
        logic [31:0]        now_ms;
        logic [15:0]        batt_mv;
        logic [15:0]        port_mv;
        logic [15:0]        boost_mv;
        logic [15:0]        solar_mv;
        logic signed [15:0] boost_ma;
    } item_t;

    // One result as it leaves the regulator.
    typedef struct packed {
        duty_t       main_duty;
        duty_t       solar_duty;
        logic        charging;
        logic        probing;
        logic [15:0] batt_report_mv;
        logic        over_current;
        logic [1:0]  fan_cmd;
    } result_t;

    // Moves a duty one count up or down, saturating at zero and the maximum.
    function automatic duty_t step_duty(duty_t d, logic up);
        duty_t r;
        if (up) begin
            r = (d >= DUTY_MAX) ? DUTY_MAX : d + duty_t'(1);
        end else begin
            r = (d == '0) ? '0 : d - duty_t'(1);
        end
        return r;
    endfunction

endpackage

@@ design/cbr_cfg_regs.sv @@
// Configuration register file of the battery charge regulator.
// Depends on cbr_pkg for the register indexes and the cfg_t struct.
module cbr_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cbr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output cbr_pkg::cfg_t                       cfg
);
    import cbr_pkg::*;

    cfg_t cfg_reg;

    // Register writes; bits above a register's width are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_main     <= 1'b0;
            cfg_reg.enable_solar    <= 1'b0;
            cfg_reg.min_diff_mv     <= 16'd5000;
            cfg_reg.max_batt_mv     <= 16'd14600;
            cfg_reg.charge_start_mv <= 16'd14200;
            cfg_reg.min_solar_mv    <= 16'd12000;
            cfg_reg.max_charge_ma   <= 15'd500;
            cfg_reg.power_save      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_ENABLE_MAIN:     cfg_reg.enable_main     <= cfg_wdata[0];
                REG_ENABLE_SOLAR:    cfg_reg.enable_solar    <= cfg_wdata[0];
                REG_MIN_DIFF_MV:     cfg_reg.min_diff_mv     <= cfg_wdata[15:0];
                REG_MAX_BATT_MV:     cfg_reg.max_batt_mv     <= cfg_wdata[15:0];
                REG_CHARGE_START_MV: cfg_reg.charge_start_mv <= cfg_wdata[15:0];
                REG_MIN_SOLAR_MV:    cfg_reg.min_solar_mv    <= cfg_wdata[15:0];
                REG_MAX_CHARGE_MA:   cfg_reg.max_charge_ma   <= cfg_wdata[14:0];
                REG_POWER_SAVE:      cfg_reg.power_save      <= cfg_wdata[0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/cbr_regulate.sv @@
// Regulation step of the battery charge regulator: holds the duties, the
// charging flag and the probe timer, and computes one result per poll.
// Depends on cbr_pkg for the item, result and configuration types.
module cbr_regulate (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  cbr_pkg::item_t    item,
    input  cbr_pkg::cfg_t     cfg,
    output cbr_pkg::result_t  result
);
    import cbr_pkg::*;

    // Regulator state.
    duty_t       main_duty_reg, main_duty_next;
    duty_t       solar_duty_reg, solar_duty_next;
    logic        charging_reg, charging_next;
    logic [31:0] last_charge_reg, last_charge_next;
    logic [31:0] last_probe_reg, last_probe_next;
    logic [15:0] probed_batt_reg, probed_batt_next;

    // Probe timer.
    logic [31:0] probe_elapsed_raw, probe_elapsed;
    logic        probe_stale, probe_store, probing;

    // Source selection and current limit.
    logic        reg_gate, port_above, solar_ok, can_main, can_solar;
    logic [15:0] deficit_mv;
    logic [25:0] deficit_k, thr_fine, thr_mid, thr_coarse;
    logic [17:0] lim8;
    logic [16:0] head_mv, cmax3;
    logic        start_ok, over_volt;
    logic [20:0] boost10, head11;
    logic signed [20:0] ma_s, lim8_s;
    logic        oc;

    // Drive decision.
    logic        main_drive, oc_hit, main_up;
    duty_t       main_tgt, main_base, solar_new;
    logic [31:0] charge_elapsed;

    // Probe timer: restarts when stale, pauses charging for half a second
    // each minute and then latches the battery voltage.
    always_comb begin
        probe_elapsed_raw = item.now_ms - last_probe_reg;
        probe_stale       = probe_elapsed_raw > STALE_MS;
        probe_elapsed     = probe_stale ? '0 : probe_elapsed_raw;
        probe_store       = charging_reg && (probe_elapsed > PROBE_END_MS);
        probing           = charging_reg && (probe_elapsed > PROBE_START_MS) && !probe_store;
        last_probe_next   = (charging_reg && (probe_stale || probe_store)) ?
                            item.now_ms : last_probe_reg;
        probed_batt_next  = (!charging_reg || probe_store) ? item.batt_mv : probed_batt_reg;
    end

    // Source choice and the tapered current limit, in eighths of a mA.
    always_comb begin
        reg_gate   = (item.now_ms > STARTUP_MS) && !probing &&
                     (item.batt_mv < cfg.max_batt_mv);
        deficit_mv = cfg.max_batt_mv - item.batt_mv;
        deficit_k  = {10'd0, deficit_mv} * TAPER_SCALE;
        thr_fine   = {10'd0, cfg.max_batt_mv} * TAPER_FINE;
        thr_mid    = {10'd0, cfg.max_batt_mv} * TAPER_MID;
        thr_coarse = {10'd0, cfg.max_batt_mv} * TAPER_COARSE;
        port_above = item.port_mv > item.batt_mv;
        solar_ok   = ({1'b0, item.solar_mv} + SOLAR_MARGIN_MV) > {1'b0, cfg.min_solar_mv};
        can_main   = reg_gate && port_above && cfg.enable_main;
        can_solar  = reg_gate && !port_above && solar_ok && cfg.enable_solar;
        lim8       = {cfg.max_charge_ma, 3'b000};
        if (reg_gate) begin
            priority if (deficit_k < thr_fine) begin
                lim8 = {3'b000, cfg.max_charge_ma};
            end else if (deficit_k < thr_mid) begin
                lim8 = {2'b00, cfg.max_charge_ma, 1'b0};
            end else if (deficit_k < thr_coarse) begin
                lim8 = {1'b0, cfg.max_charge_ma, 2'b00};
            end else begin
                lim8 = {cfg.max_charge_ma, 3'b000};
            end
        end
    end

    // Voltage and current comparisons used by both sources.
    always_comb begin
        head_mv   = {1'b0, item.batt_mv} + {1'b0, cfg.min_diff_mv};
        start_ok  = charging_reg || (item.batt_mv < cfg.charge_start_mv);
        over_volt = {2'b00, item.solar_mv} > ({2'b00, item.batt_mv} + {1'b0, item.batt_mv, 1'b0});
        boost10   = {5'd0, item.boost_mv} * 21'd10;
        head11    = {4'd0, head_mv} * 21'd11;
        ma_s      = 21'($signed(item.boost_ma));
        lim8_s    = $signed({3'b000, lim8});
        cmax3     = {2'b00, cfg.max_charge_ma} + {1'b0, cfg.max_charge_ma, 1'b0};
        oc        = (ma_s <<< 1) > $signed({4'b0000, cmax3});
    end

    // Duty decisions for the charge port and the solar booster.
    always_comb begin
        main_drive = 1'b1;
        main_tgt   = '0;
        main_base  = '0;
        main_up    = 1'b0;
        solar_new  = '0;
        oc_hit     = 1'b0;
        if (can_main) begin
            if (({1'b0, item.port_mv} > head_mv) && start_ok) begin
                oc_hit   = oc;
                main_tgt = oc ? '0 : step_duty(main_duty_reg, (ma_s <<< 3) < lim8_s);
            end
        end else if (can_solar) begin
            if (start_ok) begin
                solar_new = over_volt ? '0 : step_duty(solar_duty_reg, boost10 < head11);
                main_base = over_volt ? '0 : main_duty_reg;
                main_up   = !((solar_new >= DUTY_MAX) || (item.solar_mv < cfg.min_solar_mv)) &&
                            ({1'b0, item.boost_mv} > head_mv) && !((ma_s <<< 4) > lim8_s);
                oc_hit    = oc;
                main_tgt  = oc ? '0 : step_duty(main_base, main_up);
            end else begin
                main_drive = 1'b0;
                solar_new  = solar_duty_reg;
            end
        end
    end

    // Main duty drive: a nonzero duty marks charging; a zero duty clears the
    // flag only after the hold-off since the last nonzero duty.
    always_comb begin
        charge_elapsed   = item.now_ms - last_charge_reg;
        main_duty_next   = main_duty_reg;
        charging_next    = charging_reg;
        last_charge_next = last_charge_reg;
        solar_duty_next  = solar_new;
        if (main_drive) begin
            main_duty_next = main_tgt;
            if (main_tgt != '0) begin
                charging_next    = 1'b1;
                last_charge_next = item.now_ms;
            end else if (charge_elapsed > HOLD_OFF_MS) begin
                charging_next = 1'b0;
            end
        end
    end

    // Result of this poll.
    always_comb begin
        result.main_duty      = main_duty_next;
        result.solar_duty     = solar_duty_next;
        result.charging       = charging_next;
        result.probing        = probing;
        result.batt_report_mv = charging_next ? probed_batt_next : item.batt_mv;
        result.over_current   = oc_hit;
        result.fan_cmd        = cfg.power_save ? (charging_next ? FAN_HALF : FAN_OFF)
                                               : FAN_LEAVE;
    end

    // State update once per accepted poll.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_duty_reg   <= '0;
            solar_duty_reg  <= '0;
            charging_reg    <= 1'b0;
            last_charge_reg <= '0;
            last_probe_reg  <= '0;
            probed_batt_reg <= '0;
        end else if (step_en) begin
            main_duty_reg   <= main_duty_next;
            solar_duty_reg  <= solar_duty_next;
            charging_reg    <= charging_next;
            last_charge_reg <= last_charge_next;
            last_probe_reg  <= last_probe_next;
            probed_batt_reg <= probed_batt_next;
        end
    end

endmodule

@@ design/battery_charge_regulator.sv @@
// Top level of the battery charge regulator: input register, regulation
// step and result register. Depends on cbr_pkg, cbr_cfg_regs, cbr_regulate.
//
//  Channel  Ports                      Handshake      Carries
//  -------  -------------------------  -------------  ------------------------
//  input    s_valid s_ready s_*        valid/ready    one poll per transaction
//  result   m_valid m_ready m_*        valid/ready    one result per poll
//  config   cfg_we cfg_index cfg_wdata write enable   one register per write
//
// A poll is registered on acceptance and its result is then registered in the
// result register; one poll per cycle is sustained while the result side does
// not stall, the limit being the state update in the regulation step.
// Reset is synchronous and active low.
// A stalled result holds the input register; a new poll is still taken
// whenever the held poll moves on in the same cycle.
module battery_charge_regulator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_now_ms,
    input  logic [15:0]                     s_batt_mv,
    input  logic [15:0]                     s_port_mv,
    input  logic [15:0]                     s_boost_mv,
    input  logic [15:0]                     s_solar_mv,
    input  logic signed [15:0]              s_boost_ma,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cbr_pkg::DUTY_W-1:0]      m_main_duty,
    output logic [cbr_pkg::DUTY_W-1:0]      m_solar_duty,
    output logic                            m_charging,
    output logic                            m_probing,
    output logic [15:0]                     m_batt_report_mv,
    output logic                            m_over_current,
    output logic [1:0]                      m_fan_cmd,
    input  logic                            cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import cbr_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t step_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;

    // The held poll moves on when the result register is free or emptying.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cbr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cbr_regulate u_regulate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.now_ms   <= s_now_ms;
            item_reg.batt_mv  <= s_batt_mv;
            item_reg.port_mv  <= s_port_mv;
            item_reg.boost_mv <= s_boost_mv;
            item_reg.solar_mv <= s_solar_mv;
            item_reg.boost_ma <= s_boost_ma;
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_main_duty      = result_reg.main_duty;
    assign m_solar_duty     = result_reg.solar_duty;
    assign m_charging       = result_reg.charging;
    assign m_probing        = result_reg.probing;
    assign m_batt_report_mv = result_reg.batt_report_mv;
    assign m_over_current   = result_reg.over_current;
    assign m_fan_cmd        = result_reg.fan_cmd;

endmodule

@@ tb/battery_charge_regulator_tb.sv @@
// Self-checking testbench for battery_charge_regulator: drives polls, mirrors the
// regulation step in a behavioural predictor and checks every result in order.
// Depends on cbr_pkg (types, fan codes, register indexes) and the regulator RTL.
`timescale 1ns / 1ps

module battery_charge_regulator_tb;
    import cbr_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PRINT_LIMIT  = 40;
    localparam int          DUTY_TOP     = PWM_PERIOD - PWM_PERIOD / 8;
    localparam logic [31:0] BOOT_MS      = 32'd30000;
    localparam logic [31:0] PROBE_OPEN   = 32'd60000;
    localparam logic [31:0] PROBE_CLOSE  = 32'd60500;
    localparam logic [31:0] HOLD_MS      = 32'd120000;
    localparam logic [31:0] STALE_PROBE  = 32'd180000;
    localparam longint      SOLAR_SLACK  = 2000;
    localparam longint      PER_MILLE    = 1000;
    localparam longint      TAPER_EIGHTH = 13;
    localparam longint      TAPER_QUART  = 27;
    localparam longint      TAPER_HALF   = 41;

    // Clock, reset and block inputs, all known from time zero.
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [31:0]             s_now_ms = '0;
    logic [15:0]             s_batt_mv = '0;
    logic [15:0]             s_port_mv = '0;
    logic [15:0]             s_boost_mv = '0;
    logic [15:0]             s_solar_mv = '0;
    logic signed [15:0]      s_boost_ma = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [DUTY_W-1:0]       m_main_duty;
    logic [DUTY_W-1:0]       m_solar_duty;
    logic                    m_charging;
    logic                    m_probing;
    logic [15:0]             m_batt_report_mv;
    logic                    m_over_current;
    logic [1:0]              m_fan_cmd;
    logic                    cfg_we = 1'b0;
    cfg_index_t              cfg_index = REG_ENABLE_MAIN;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    // Predictor state and the register copy it works from.
    cfg_t        live_cfg;
    int          main_duty_now;
    int          solar_duty_now;
    bit          charging_now;
    logic [31:0] last_charge_ms;
    logic [31:0] last_probe_ms;
    logic [15:0] probe_hold_mv;

    item_t       poll_backlog[$];
    result_t     due_results[$];
    item_t       held_poll;
    result_t     seen_result;
    result_t     due_result;
    bit          gaps_on = 1'b1;
    logic [31:0] poll_clock = '0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          polls_taken = 0;
    int          results_checked = 0;
    int          charging_seen = 0;
    int          probing_seen = 0;
    int          cuts_seen = 0;
    int          peak_main = 0;
    int          settings_used = 0;

    battery_charge_regulator DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_now_ms         (s_now_ms),
        .s_batt_mv        (s_batt_mv),
        .s_port_mv        (s_port_mv),
        .s_boost_mv       (s_boost_mv),
        .s_solar_mv       (s_solar_mv),
        .s_boost_ma       (s_boost_ma),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_main_duty      (m_main_duty),
        .m_solar_duty     (m_solar_duty),
        .m_charging       (m_charging),
        .m_probing        (m_probing),
        .m_batt_report_mv (m_batt_report_mv),
        .m_over_current   (m_over_current),
        .m_fan_cmd        (m_fan_cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [15:0] mv16(input longint v);
        return 16'(clip(v, 0, 65535));
    endfunction

    // Uniform signed value in [lo, hi].
    function automatic longint spread(input longint lo, input longint hi);
        return lo + longint'($urandom_range(int'(hi - lo)));
    endfunction

    function automatic int sat_duty(input longint d);
        return int'(clip(d, 0, DUTY_TOP));
    endfunction

    // A zero main duty releases the charging flag only after the hold-off.
    function automatic void set_main_duty(input longint d, input logic [31:0] stamp);
        logic [31:0] idle_for;
        main_duty_now = sat_duty(d);
        idle_for = stamp - last_charge_ms;
        if (main_duty_now == 0) begin
            if (idle_for > HOLD_MS) charging_now = 1'b0;
        end else begin
            charging_now = 1'b1;
            last_charge_ms = stamp;
        end
    endfunction

    // One regulation step: updates the predictor state and returns the result.
    function automatic result_t regulate_poll(input item_t p);
        logic [31:0] stamp;
        logic [31:0] since_probe;
        longint      batt, port, boost, solar, ma, mx, cmax, head, lim8, gap;
        longint      start_mv, min_sol;
        bit          probing, latch, use_port, use_solar, cut, oc;
        longint      sd, md;
        result_t     r;

        stamp    = p.now_ms;
        batt     = longint'(p.batt_mv);
        port     = longint'(p.port_mv);
        boost    = longint'(p.boost_mv);
        solar    = longint'(p.solar_mv);
        ma       = longint'($signed(p.boost_ma));
        mx       = longint'(live_cfg.max_batt_mv);
        cmax     = longint'(live_cfg.max_charge_ma);
        start_mv = longint'(live_cfg.charge_start_mv);
        min_sol  = longint'(live_cfg.min_solar_mv);
        head     = batt + longint'(live_cfg.min_diff_mv);
        lim8     = cmax * 8;
        probing  = 1'b0;
        latch    = 1'b0;
        use_port = 1'b0;
        use_solar = 1'b0;
        cut      = 1'b0;

        // Probe timer: pause, then latch the battery voltage.
        if (charging_now) begin
            since_probe = stamp - last_probe_ms;
            if (since_probe > STALE_PROBE) begin
                last_probe_ms = stamp;
                since_probe = '0;
            end
            if (since_probe > PROBE_OPEN) probing = 1'b1;
            if (since_probe > PROBE_CLOSE) begin
                latch = 1'b1;
                probing = 1'b0;
                last_probe_ms = stamp;
            end
        end
        if (!charging_now || latch) probe_hold_mv = p.batt_mv;

        // Source selection and current taper near full charge.
        if (stamp > BOOT_MS && !probing && batt < mx) begin
            gap = mx - batt;
            if (port > batt) use_port = 1'b1;
            else if (solar > min_sol - SOLAR_SLACK) use_solar = 1'b1;
            if (gap * PER_MILLE < TAPER_EIGHTH * mx) lim8 = cmax;
            else if (gap * PER_MILLE < TAPER_QUART * mx) lim8 = cmax * 2;
            else if (gap * PER_MILLE < TAPER_HALF * mx) lim8 = cmax * 4;
        end
        oc = (2 * ma > 3 * cmax);
        use_port  = use_port && live_cfg.enable_main;
        use_solar = use_solar && live_cfg.enable_solar;

        if (!use_port && !use_solar) set_main_duty(0, stamp);
        if (!use_solar) solar_duty_now = 0;

        // Charge port path.
        if (use_port) begin
            if (port > head && (charging_now || batt < start_mv)) begin
                if (oc) begin
                    set_main_duty(0, stamp);
                    cut = 1'b1;
                end else begin
                    set_main_duty(main_duty_now + ((8 * ma < lim8) ? 1 : -1), stamp);
                end
            end else begin
                set_main_duty(0, stamp);
            end
        end

        // Solar booster path.
        if (use_solar && (charging_now || batt < start_mv)) begin
            sd = solar_duty_now + ((10 * boost < 11 * head) ? 1 : -1);
            if (solar > batt * 3) begin
                solar_duty_now = 0;
                set_main_duty(0, stamp);
            end else begin
                solar_duty_now = sat_duty(sd);
            end
            md = main_duty_now;
            if (solar_duty_now >= DUTY_TOP || solar < min_sol) md = md - 1;
            else if (boost > head) md = md + ((16 * ma > lim8) ? -1 : 1);
            else md = md - 1;
            if (oc) begin
                set_main_duty(0, stamp);
                cut = 1'b1;
            end else begin
                set_main_duty(md, stamp);
            end
        end

        r.main_duty      = duty_t'(main_duty_now);
        r.solar_duty     = duty_t'(solar_duty_now);
        r.charging       = charging_now;
        r.probing        = probing;
        r.batt_report_mv = charging_now ? probe_hold_mv : p.batt_mv;
        r.over_current   = cut;
        r.fan_cmd        = !live_cfg.power_save ? FAN_LEAVE :
                           (charging_now ? FAN_HALF : FAN_OFF);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_poll(input logic [31:0] t, input logic [15:0] b, input logic [15:0] p,
                              input logic [15:0] bo, input logic [15:0] so,
                              input logic signed [15:0] ma);
        item_t it;
        it.now_ms   = t;
        it.batt_mv  = b;
        it.port_mv  = p;
        it.boost_mv = bo;
        it.solar_mv = so;
        it.boost_ma = ma;
        poll_backlog.push_back(it);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Writes every register; spare upper bits carry junk that must be ignored.
    task automatic load_settings(input logic en_m, input logic en_s, input logic [15:0] diff,
                                 input logic [15:0] maxb, input logic [15:0] start,
                                 input logic [15:0] minsol, input logic [14:0] maxma,
                                 input logic ps);
        write_reg(REG_ENABLE_MAIN, {15'($urandom), en_m});
        write_reg(REG_ENABLE_SOLAR, {15'($urandom), en_s});
        write_reg(REG_MIN_DIFF_MV, diff);
        write_reg(REG_MAX_BATT_MV, maxb);
        write_reg(REG_CHARGE_START_MV, start);
        write_reg(REG_MIN_SOLAR_MV, minsol);
        write_reg(REG_MAX_CHARGE_MA, {1'($urandom), maxma});
        write_reg(REG_POWER_SAVE, {15'($urandom), ps});
        settings_used++;
    endtask

    // Sender holds off until the block has returned every outstanding result.
    task automatic wait_idle();
        do @(negedge aclk);
        while (poll_backlog.size() != 0 || s_valid || due_results.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    // Register writes are mirrored into the predictor; reset restores defaults.
    always @(posedge aclk) begin
        if (!aresetn) begin
            live_cfg.enable_main     = 1'b0;
            live_cfg.enable_solar    = 1'b0;
            live_cfg.min_diff_mv     = 16'd5000;
            live_cfg.max_batt_mv     = 16'd14600;
            live_cfg.charge_start_mv = 16'd14200;
            live_cfg.min_solar_mv    = 16'd12000;
            live_cfg.max_charge_ma   = 15'd500;
            live_cfg.power_save      = 1'b0;
            main_duty_now  = 0;
            solar_duty_now = 0;
            charging_now   = 1'b0;
            last_charge_ms = '0;
            last_probe_ms  = '0;
            probe_hold_mv  = '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENABLE_MAIN:     live_cfg.enable_main     = cfg_wdata[0];
                REG_ENABLE_SOLAR:    live_cfg.enable_solar    = cfg_wdata[0];
                REG_MIN_DIFF_MV:     live_cfg.min_diff_mv     = cfg_wdata;
                REG_MAX_BATT_MV:     live_cfg.max_batt_mv     = cfg_wdata;
                REG_CHARGE_START_MV: live_cfg.charge_start_mv = cfg_wdata;
                REG_MIN_SOLAR_MV:    live_cfg.min_solar_mv    = cfg_wdata;
                REG_MAX_CHARGE_MA:   live_cfg.max_charge_ma   = cfg_wdata[14:0];
                REG_POWER_SAVE:      live_cfg.power_save      = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Poll driver: predicts each accepted transaction, then offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                due_results.push_back(regulate_poll(held_poll));
                polls_taken++;
            end
            if (!s_valid || s_ready) begin
                if (poll_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 28)) begin
                    held_poll = poll_backlog.pop_front();
                    s_valid    <= 1'b1;
                    s_now_ms   <= held_poll.now_ms;
                    s_batt_mv  <= held_poll.batt_mv;
                    s_port_mv  <= held_poll.port_mv;
                    s_boost_mv <= held_poll.boost_mv;
                    s_solar_mv <= held_poll.solar_mv;
                    s_boost_ma <= held_poll.boost_ma;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !(gaps_on && $urandom_range(99) < 28);
    end

    // Result monitor: compares each transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result.main_duty      = m_main_duty;
            seen_result.solar_duty     = m_solar_duty;
            seen_result.charging       = m_charging;
            seen_result.probing        = m_probing;
            seen_result.batt_report_mv = m_batt_report_mv;
            seen_result.over_current   = m_over_current;
            seen_result.fan_cmd        = m_fan_cmd;
            if (due_results.size() == 0) begin
                flag_mismatch("result with no poll outstanding", m_main_duty, 0);
            end else begin
                due_result = due_results.pop_front();
                if (seen_result.main_duty !== due_result.main_duty)
                    flag_mismatch("main_duty", seen_result.main_duty, due_result.main_duty);
                if (seen_result.solar_duty !== due_result.solar_duty)
                    flag_mismatch("solar_duty", seen_result.solar_duty, due_result.solar_duty);
                if (seen_result.charging !== due_result.charging)
                    flag_mismatch("charging", seen_result.charging, due_result.charging);
                if (seen_result.probing !== due_result.probing)
                    flag_mismatch("probing", seen_result.probing, due_result.probing);
                if (seen_result.batt_report_mv !== due_result.batt_report_mv)
                    flag_mismatch("batt_report_mv", seen_result.batt_report_mv,
                                  due_result.batt_report_mv);
                if (seen_result.over_current !== due_result.over_current)
                    flag_mismatch("over_current", seen_result.over_current,
                                  due_result.over_current);
                if (seen_result.fan_cmd !== due_result.fan_cmd)
                    flag_mismatch("fan_cmd", seen_result.fan_cmd, due_result.fan_cmd);
                results_checked++;
                if (due_result.charging) charging_seen++;
                if (due_result.probing) probing_seen++;
                if (due_result.over_current) cuts_seen++;
                if (int'(due_result.main_duty) > peak_main) peak_main = due_result.main_duty;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, due_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus: directed polls, then randomised phases under different settings.
    initial begin
        int          n, phase, phase_polls;
        bit          climb, port_live;
        longint      mx, cm, ms, bw, lo_b, hi_b, hd;
        logic [31:0] stride, t;
        logic [15:0] bv, pv, bov, sov;
        logic signed [15:0] mav;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed polls under the default thresholds with both sources enabled.
        load_settings(1'b1, 1'b1, 16'd5000, 16'd14600, 16'd14200, 16'd12000, 15'd500, 1'b0);
        queue_poll(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'sd0);
        queue_poll(32'd30000, 16'd12000, 16'd18000, 16'd17000, 16'd0, 16'sd0);
        queue_poll(32'd30001, 16'd12000, 16'd18000, 16'd17000, 16'd0, 16'sd100);
        queue_poll(32'd30050, 16'd12000, 16'd18000, 16'd17000, 16'd0, 16'sd800);
        queue_poll(32'd30100, 16'd12000, 16'd18000, 16'd17000, 16'd0, 16'sd32767);
        queue_poll(32'd30150, 16'd12000, 16'd18000, 16'd17000, 16'd0, -16'sd32768);
        queue_poll(32'd60100, 16'd12000, 16'd18000, 16'd17000, 16'd0, 16'sd0);
        queue_poll(32'd60700, 16'd12150, 16'd18000, 16'd17000, 16'd0, 16'sd0);
        queue_poll(32'd60750, 16'd14500, 16'hFFFF, 16'd17000, 16'd0, 16'sd70);
        queue_poll(32'd60800, 16'd14300, 16'hFFFF, 16'd17000, 16'd0, 16'sd120);
        queue_poll(32'd60850, 16'd14100, 16'hFFFF, 16'd17000, 16'd0, 16'sd240);
        queue_poll(32'd60900, 16'd14600, 16'hFFFF, 16'd17000, 16'd0, 16'sd0);
        queue_poll(32'd60950, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd0);
        queue_poll(32'd61000, 16'd12000, 16'd11000, 16'd17500, 16'd13000, 16'sd100);
        queue_poll(32'd61050, 16'd12000, 16'd11000, 16'd16000, 16'd40000, 16'sd0);
        queue_poll(32'd61100, 16'd12000, 16'd0, 16'd17500, 16'd11000, 16'sd0);
        queue_poll(32'd61150, 16'd12000, 16'd0, 16'd17500, 16'd13000, 16'sd700);
        queue_poll(32'd300000, 16'd12000, 16'd0, 16'd0, 16'd0, 16'sd0);
        queue_poll(32'd300050, 16'd14300, 16'd20000, 16'd0, 16'd0, 16'sd0);
        queue_poll(32'd300100, 16'd12000, 16'd16999, 16'd0, 16'd0, 16'sd0);
        queue_poll(32'hFFFF_FFF0, 16'd12000, 16'd18000, 16'd0, 16'd0, 16'sd0);
        queue_poll(32'h0000_0010, 16'd12000, 16'd18000, 16'd0, 16'd0, 16'sd0);
        poll_clock = 32'd40000;

        for (phase = 0; phase < 8; phase++) begin
            wait_idle();
            climb = 1'b0;
            phase_polls = 100;
            case (phase)
                0: begin
                    load_settings(1'b1, 1'b1, 16'd5000, 16'd14600, 16'd14200, 16'd12000,
                                  15'd500, 1'b0);
                    phase_polls = 110;
                end
                1: begin
                    // Long unbroken charge so the main duty reaches its ceiling.
                    load_settings(1'b1, 1'b0, 16'd0, 16'd60000, 16'hFFFF, 16'd0, 15'd20000,
                                  1'b1);
                    climb = 1'b1;
                    phase_polls = 1000;
                    poll_clock += 32'd100_000_000;
                end
                2: begin
                    load_settings(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 15'd0, 1'b0);
                    phase_polls = 90;
                end
                3: begin
                    load_settings(1'b0, 1'b1, 16'd0, 16'd1, 16'hFFFF, 16'd0, 15'd20000, 1'b1);
                    phase_polls = 90;
                end
                4: begin
                    // Solar threshold below the margin makes the solar test signed.
                    load_settings(1'b1, 1'b1, 16'd2000, 16'd14600, 16'd14400, 16'd1500,
                                  15'd1200, 1'b0);
                    phase_polls = 110;
                end
                default: begin
                    mx = $urandom_range(16000, 12000);
                    load_settings(1'($urandom), 1'($urandom), 16'($urandom_range(8000)),
                                  16'(mx), 16'(mx - $urandom_range(800)),
                                  16'($urandom_range(15000)), 15'($urandom_range(20000)),
                                  1'($urandom));
                end
            endcase
            gaps_on = !climb;

            mx = longint'(live_cfg.max_batt_mv);
            cm = longint'(live_cfg.max_charge_ma);
            ms = longint'(live_cfg.min_solar_mv);
            lo_b = clip(mx - 2600, 0, 65535);
            hi_b = clip(mx + 200, 0, 65535);
            bw = clip(mx - spread(0, 1500), 0, 65535);
            port_live = climb ? 1'b1 : 1'($urandom);

            for (n = 0; n < phase_polls; n++) begin
                // Poll timestamps: mostly short steps, some long gaps, rare jumps.
                if (climb) stride = $urandom_range(30, 1);
                else if ($urandom_range(99) < 60) stride = $urandom_range(400, 20);
                else if ($urandom_range(99) < 80) stride = $urandom_range(5000, 400);
                else stride = $urandom_range(200000, 5000);
                poll_clock += stride;
                t = (!climb && $urandom_range(99) < 2) ? $urandom : poll_clock;

                if (!climb && $urandom_range(99) < 3) port_live = !port_live;
                bw = clip(bw + spread(-40, 40), lo_b, hi_b);
                bv = (climb && bw >= mx) ? 16'(mx - 1) : 16'(bw);
                hd = longint'(bv) + longint'(live_cfg.min_diff_mv);

                if (!climb && $urandom_range(99) < 10) begin
                    // Unshaped noise across the full field ranges.
                    bv  = 16'($urandom);
                    pv  = 16'($urandom);
                    bov = 16'($urandom);
                    sov = 16'($urandom);
                    mav = 16'($urandom);
                end else begin
                    if (climb) pv = mv16(hd + spread(1, 1000));
                    else if (port_live) pv = mv16(hd + spread(-600, 3000));
                    else pv = mv16(longint'(bv) - spread(0, 3000));
                    if ($urandom_range(19) == 0) sov = mv16(3 * longint'(bv) + spread(-50, 50));
                    else sov = mv16(ms + spread(-3000, 5000));
                    bov = mv16(hd + spread(-1500, 1500));
                    if (climb) mav = ($urandom_range(99) == 0) ? 16'(spread(20000, 30000))
                                                              : 16'(spread(0, 2000));
                    else mav = 16'(clip(spread(-200, 2 * cm + 400), -32768, 32767));
                end
                queue_poll(t, bv, pv, bov, sov, mav);
            end
        end

        wait_idle();
        repeat (5) @(posedge aclk);

        $display("Covered %0d polls over %0d register settings; %0d results checked.",
                 polls_taken, settings_used, results_checked);
        $display("Charging in %0d results, probing in %0d, %0d over-current cuts, peak duty %0d.",
                 charging_seen, probing_seen, cuts_seen, peak_main);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
